// File: rtl/mfls_pkg.sv
// Package for the multiplexed fault LED scanner.
// Holds row codes, select masks and bit positions; no dependencies.
package mfls_pkg;

   localparam int WordWidth = 16;
   localparam int PortWidth = 8;
   localparam int TickWidth = 8;
   localparam int FrameWidth = 32;

   typedef enum logic [1:0] {
      ROW_LAST = 2'd0,
      ROW_ONE = 2'd1,
      ROW_TWO = 2'd2,
      ROW_THREE = 2'd3
   } row_type;

   localparam logic [PortWidth-1:0] SelOne = 8'h01;
   localparam logic [PortWidth-1:0] SelTwo = 8'h02;
   localparam logic [PortWidth-1:0] SelThree = 8'h04;
   localparam logic [PortWidth-1:0] SelLast = 8'h80;

   localparam int BitOk = 12;
   localparam int BitFault = 13;

   localparam logic [2:0] SlotCount = 3'd6;
   localparam logic [2:0] CombWindow = 3'd6;

endpackage

// File: rtl/mfls_if.sv
// Valid/ready channel interface for the scanner.
// Depends on mfls_pkg for payload widths.
interface mfls_req_if;
   logic valid;
   logic ready;
   logic [mfls_pkg::WordWidth-1:0] board_fault_word;
   logic [mfls_pkg::WordWidth-1:0] stepup_fault_word;
   logic [mfls_pkg::WordWidth-1:0] input_cap_word;
   logic [mfls_pkg::WordWidth-1:0] input_zener_word;
   logic [mfls_pkg::WordWidth-1:0] ground_zener_word;
   logic [mfls_pkg::WordWidth-1:0] output_cap_word;
   logic [mfls_pkg::WordWidth-1:0] output_zener_word;
   logic [mfls_pkg::WordWidth-1:0] inout_zener_word;
   logic [mfls_pkg::WordWidth-1:0] voltage_word;

   modport source (output valid, output board_fault_word, output stepup_fault_word,
      output input_cap_word, output input_zener_word, output ground_zener_word,
      output output_cap_word, output output_zener_word, output inout_zener_word,
      output voltage_word, input ready);
   modport sink (input valid, input board_fault_word, input stepup_fault_word,
      input input_cap_word, input input_zener_word, input ground_zener_word,
      input output_cap_word, input output_zener_word, input inout_zener_word,
      input voltage_word, output ready);
endinterface

interface mfls_rsp_if;
   logic valid;
   logic ready;
   logic [mfls_pkg::PortWidth-1:0] port_level;
   logic [mfls_pkg::PortWidth-1:0] port_direction;

   modport source (output valid, output port_level, output port_direction, input ready);
   modport sink (input valid, input port_level, input port_direction, output ready);
endinterface

// File: rtl/multiplexed_fault_led_scanner.sv
// Multiplexed fault LED scanner, top level.
// Depends on mfls_pkg and the channel interfaces in mfls_if.sv.
//
// Usage: each transfer on req_ is one refresh tick carrying nine 16-bit fault
// words. Each tick yields one transfer on rsp_: port_level (the current row's
// LED bits remapped to port pins) and port_direction (row select ORed with
// level). The row comes from the top two bits of an internal 8-bit tick
// counter; on the last row's tick a 32-bit frame counter steps and the next
// displayed word is chosen from the fault words (board faults win; else the
// combined OK word when its fault bit is clear or in window six; else a nonzero
// slot word from a rotation of six). The result is registered.
// Throughput: one tick per cycle while rsp_ drains; the state update and row
// decode are one level of logic between the request and the result register.
// Stall: a held result keeps its register; a new request is taken only when
// the result register is empty or is being drained in the same cycle, so no
// result is lost or repeated.
// Reset: synchronous, active high; tick counter, frame counter and displayed
// word clear to zero and the result register empties.
module multiplexed_fault_led_scanner (
   input logic clock,
   input logic reset,
   mfls_req_if.sink req_chan,
   mfls_rsp_if.source rsp_chan
);

   logic [mfls_pkg::TickWidth-1:0] row_tick_ff, row_tick_in;
   logic [mfls_pkg::FrameWidth-1:0] frame_count_ff, frame_count_in;
   logic [mfls_pkg::WordWidth-1:0] shown_word_ff, shown_word_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [mfls_pkg::PortWidth-1:0] level_ff, level_in;
   logic [mfls_pkg::PortWidth-1:0] direction_ff, direction_in;

   logic accept;
   mfls_pkg::row_type row;
   logic [mfls_pkg::PortWidth-1:0] level;
   logic [mfls_pkg::PortWidth-1:0] select;
   logic [mfls_pkg::WordWidth-1:0] s;
   logic [mfls_pkg::WordWidth-1:0] board_or;
   logic [mfls_pkg::WordWidth-1:0] slot_word;
   logic [mfls_pkg::WordWidth-1:0] comb_raw;
   logic [mfls_pkg::WordWidth-1:0] comb;
   logic [2:0] slot;
   logic [2:0] window;
   logic [mfls_pkg::WordWidth-1:0] next_word;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.port_level = level_ff;
   assign rsp_chan.port_direction = direction_ff;

   assign row = mfls_pkg::row_type'(row_tick_ff[mfls_pkg::TickWidth-1 -: 2]);
   assign s = shown_word_ff;

   // Row decode from the displayed word as it stood before this tick.
   always_comb begin
      level = '0;
      select = mfls_pkg::SelLast;
      unique case (row)
         mfls_pkg::ROW_ONE: begin
            level[1] = s[13];
            level[2] = s[9];
            level[6] = s[10];
            level[7] = s[11];
            select = mfls_pkg::SelOne;
         end
         mfls_pkg::ROW_TWO: begin
            level[0] = s[0];
            level[2] = s[14];
            level[6] = s[2];
            level[7] = s[1];
            select = mfls_pkg::SelTwo;
         end
         mfls_pkg::ROW_THREE: begin
            level[1] = s[3];
            level[0] = s[4];
            level[6] = s[15];
            level[7] = s[5];
            select = mfls_pkg::SelThree;
         end
         mfls_pkg::ROW_LAST: begin
            level[1] = s[8];
            level[2] = s[7];
            level[6] = s[6];
            level[0] = s[12];
            select = mfls_pkg::SelLast;
         end
         default: begin
            level = '0;
            select = mfls_pkg::SelLast;
         end
      endcase
   end

   // Frame update, evaluated against the incremented frame counter.
   assign frame_count_in = (accept && row == mfls_pkg::ROW_LAST) ?
      frame_count_ff + 32'd1 : frame_count_ff;
   assign slot = frame_count_in[14:12];
   assign window = frame_count_in[15:13];
   assign board_or = req_chan.board_fault_word | req_chan.stepup_fault_word;
   assign comb_raw = req_chan.input_cap_word | req_chan.input_zener_word |
      req_chan.ground_zener_word | req_chan.output_cap_word |
      req_chan.output_zener_word | req_chan.inout_zener_word | req_chan.voltage_word;

   always_comb begin
      unique case (slot)
         3'd0: slot_word = req_chan.input_cap_word;
         3'd1: slot_word = req_chan.input_zener_word;
         3'd2: slot_word = req_chan.ground_zener_word;
         3'd3: slot_word = req_chan.output_cap_word;
         3'd4: slot_word = req_chan.output_zener_word;
         3'd5: slot_word = req_chan.inout_zener_word;
         default: slot_word = '0;
      endcase
   end

   always_comb begin
      comb = comb_raw;
      if (!comb_raw[mfls_pkg::BitFault]) begin
         comb[mfls_pkg::BitOk] = 1'b1;
      end
   end

   always_comb begin
      next_word = shown_word_ff;
      priority if (board_or != '0) begin
         next_word = board_or;
      end else begin
         if (slot < mfls_pkg::SlotCount && slot_word != '0) begin
            next_word = slot_word;
         end
         if (!comb_raw[mfls_pkg::BitFault]) begin
            next_word = comb;
         end
         if (window == mfls_pkg::CombWindow && comb != '0) begin
            next_word = comb;
         end
      end
   end

   always_comb begin
      row_tick_in = row_tick_ff;
      shown_word_in = shown_word_ff;
      rsp_valid_in = rsp_valid_ff;
      level_in = level_ff;
      direction_in = direction_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         row_tick_in = row_tick_ff + 8'd1;
         if (row == mfls_pkg::ROW_LAST) begin
            shown_word_in = next_word;
         end
         rsp_valid_in = 1'b1;
         level_in = level;
         direction_in = select | level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_tick_ff <= '0;
         frame_count_ff <= '0;
         shown_word_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_tick_ff <= row_tick_in;
         frame_count_ff <= frame_count_in;
         shown_word_ff <= shown_word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      direction_ff <= direction_in;
   end

   // Every result carries at most one row select bit that is not also a level bit.
   a_one_select: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $countones(rsp_chan.port_direction &
         (mfls_pkg::SelOne | mfls_pkg::SelTwo | mfls_pkg::SelThree | mfls_pkg::SelLast)
         & ~rsp_chan.port_level) <= 1)
      else $error("result carries more than one select bit");

   // Each transfer advances the tick counter by one.
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> row_tick_ff == $past(row_tick_ff) + 8'd1)
      else $error("tick counter did not advance");

   // Frame counter and displayed word move only on a last-row transfer.
   a_frame_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && row == mfls_pkg::ROW_LAST) |=> $stable(frame_count_ff) &&
         $stable(shown_word_ff))
      else $error("frame state changed off the last row");

   // A stalled result is not replaced.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !accept)
      else $error("request taken over a stalled result");

endmodule
